/* hw/rtl/fir_q16_pkg.sv */
// Shared types and constants for the Q16 direct-form FIR filter.
// No dependencies; imported by fir_q16_mac and fir_filter_q16_taps_unit.
`timescale 1ns / 1ps
`default_nettype none

package fir_q16_pkg;

  localparam int MAX_TAPS_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int TAP_BITS    = 32;
  localparam int ACC_BITS    = 64;
  localparam int OUT_BITS    = 32;
  localparam int COUNT_BITS  = 7;
  localparam int INDEX_BITS  = 6;
  localparam int ACTION_BITS = 2;
  localparam int ADDR_BITS   = 3;
  localparam int DATA_BITS   = 32;
  localparam int REG_LSB     = 2;

  localparam logic [ACTION_BITS-1:0] ACT_TAP    = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_SETTLE = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_SAMPLE = 2'd2;

  localparam logic [ADDR_BITS-REG_LSB-1:0] REG_TAP_COUNT = 1'b0;
  localparam logic [COUNT_BITS-1:0]        TAP_COUNT_RESET = 7'd64;

  typedef struct packed {
    logic clear;
    logic mul_v;
    logic round;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
  } mac_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/fir_filter_q16_taps_unit.sv */
// Top level of the Q16 direct-form FIR filter: sequencer, tap store,
// history ring and APB register. Uses fir_q16_pkg and fir_q16_mac.
//
//   channel  | handshake          | carries
//   ---------+--------------------+---------------------------------------------
//   input    | in_valid/in_ready  | action, tap index/value, sample, settle level
//   result   | out_valid/out_ready| filtered
//   config   | psel/penable/pready| tap_count at byte address 0
//
// Tap write: taken while idle. Sample: a pass over n taps, n the effective
// tap count; settle: a pass over all MAX_TAPS entries. One multiplier and one
// read port per memory, one tap per cycle; then drain, round and output.
// After reset a clearing pass over all MAX_TAPS entries zeroes both memories.
// A waiting result sits in the output register; the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module fir_filter_q16_taps_unit #(
  parameter int MAX_TAPS    = fir_q16_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = fir_q16_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = fir_q16_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  output logic                                       in_ready,
  input  logic [fir_q16_pkg::ACTION_BITS-1:0]        in_action,
  input  logic [fir_q16_pkg::INDEX_BITS-1:0]         in_tap_index,
  input  logic signed [fir_q16_pkg::TAP_BITS-1:0]    in_tap_value,
  input  logic signed [SAMPLE_BITS-1:0]              in_sample,
  input  logic signed [SAMPLE_BITS-1:0]              in_settle_level,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic signed [fir_q16_pkg::OUT_BITS-1:0]    out_filtered,
  input  logic                                       psel,
  input  logic                                       penable,
  input  logic                                       pwrite,
  input  logic [fir_q16_pkg::ADDR_BITS-1:0]          paddr,
  input  logic [fir_q16_pkg::DATA_BITS-1:0]          pwdata,
  output logic [fir_q16_pkg::DATA_BITS-1:0]          prdata,
  output logic                                       pready
);
  import fir_q16_pkg::*;

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam logic [CW-1:0] LAST_IDX = CW'(MAX_TAPS - 1);

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RUN, S_DRAIN, S_RND, S_OUT} state_t;

  state_t                        state_r, state_nxt;
  logic                          settle_r, settle_nxt;
  logic [CW-1:0]                 idx_r, idx_nxt;
  logic [AW-1:0]                 wp_r, wp_nxt;
  logic [AW-1:0]                 hist_ptr_r, hist_ptr_nxt;
  logic signed [SAMPLE_BITS-1:0] level_r, level_nxt;
  logic                          rd_v_r, rd_v_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [OUT_BITS-1:0]    out_filtered_r, out_filtered_nxt;
  logic [COUNT_BITS-1:0]         tap_count_r, tap_count_nxt;

  logic signed [TAP_BITS-1:0]    tap_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic                          tap_we, hist_we;
  logic [AW-1:0]                 tap_wa, hist_wa, tap_ra, hist_ra;
  logic signed [TAP_BITS-1:0]    tap_wd, tap_rd_r;
  logic signed [SAMPLE_BITS-1:0] hist_wd, hist_rd_r;

  logic [CW-1:0]                 n_eff, n_last, wp_inc;
  logic [AW-1:0]                 wp_eff, wp_after;
  logic                          in_fire, cfg_wr;
  mac_ctl_t                      mac_ctl;
  mac_sts_t                      mac_sts;
  logic signed [OUT_BITS-1:0]    mac_result;

  fir_q16_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_i    (mac_ctl),
    .tap_i    (tap_rd_r),
    .data_i   (settle_r ? level_r : hist_rd_r),
    .sts_o    (mac_sts),
    .result_o (mac_result)
  );

  assign in_ready     = (state_r == S_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite && pready;
  assign prdata       = (paddr[ADDR_BITS-1:REG_LSB] == REG_TAP_COUNT) ?
                        DATA_BITS'(tap_count_r) : '0;

  always_comb begin
    if (tap_count_r == '0) begin
      n_eff = CW'(1);
    end else if (int'(tap_count_r) > MAX_TAPS) begin
      n_eff = CW'(MAX_TAPS);
    end else begin
      n_eff = CW'(tap_count_r);
    end
    n_last   = n_eff - CW'(1);
    wp_eff   = (CW'(wp_r) >= n_eff) ? '0 : wp_r;   // ring shrank
    wp_inc   = CW'(wp_eff) + CW'(1);
    wp_after = (wp_inc >= n_eff) ? '0 : wp_inc[AW-1:0];
  end

  always_comb begin
    state_nxt        = state_r;
    settle_nxt       = settle_r;
    idx_nxt          = idx_r;
    wp_nxt           = wp_r;
    hist_ptr_nxt     = hist_ptr_r;
    level_nxt        = level_r;
    rd_v_nxt         = 1'b0;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_filtered_nxt = out_filtered_r;
    tap_count_nxt    = tap_count_r;
    tap_we           = 1'b0;
    tap_wa           = idx_r[AW-1:0];
    tap_wd           = '0;
    hist_we          = 1'b0;
    hist_wa          = idx_r[AW-1:0];
    hist_wd          = '0;
    tap_ra           = idx_r[AW-1:0];
    hist_ra          = hist_ptr_r;
    mac_ctl          = '0;
    mac_ctl.mul_v    = rd_v_r;

    if (cfg_wr && paddr[ADDR_BITS-1:REG_LSB] == REG_TAP_COUNT) begin
      tap_count_nxt = pwdata[COUNT_BITS-1:0];
    end

    case (state_r)
      S_CLR: begin
        tap_we  = 1'b1;
        hist_we = 1'b1;
        if (idx_r == LAST_IDX) begin
          idx_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_TAP: begin
              if (int'(in_tap_index) < MAX_TAPS) begin
                tap_we = 1'b1;
                tap_wa = AW'(in_tap_index);
                tap_wd = in_tap_value;
              end
            end
            ACT_SETTLE: begin
              settle_nxt    = 1'b1;
              level_nxt     = in_settle_level;
              wp_nxt        = '0;
              idx_nxt       = '0;
              mac_ctl.clear = 1'b1;
              state_nxt     = S_RUN;
            end
            ACT_SAMPLE: begin
              settle_nxt    = 1'b0;
              hist_we       = 1'b1;
              hist_wa       = wp_eff;
              hist_wd       = in_sample;
              hist_ptr_nxt  = wp_eff;
              wp_nxt        = wp_after;
              idx_nxt       = '0;
              mac_ctl.clear = 1'b1;
              state_nxt     = S_RUN;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        if (settle_r) begin
          // fill the whole ring, accumulate only the taps in use
          hist_we  = 1'b1;
          hist_wd  = level_r;
          rd_v_nxt = (idx_r < n_eff);
          if (idx_r == LAST_IDX) begin
            state_nxt = S_DRAIN;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end else begin
          rd_v_nxt     = 1'b1;
          hist_ptr_nxt = (hist_ptr_r == '0) ? n_last[AW-1:0] : hist_ptr_r - AW'(1);
          if (idx_r == n_last) begin
            state_nxt = S_DRAIN;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end
      end
      S_DRAIN: begin
        if (!rd_v_r && !mac_sts.busy) begin
          state_nxt = S_RND;
        end
      end
      S_RND: begin
        mac_ctl.round = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_filtered_nxt = mac_result;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      settle_r    <= 1'b0;
      idx_r       <= '0;
      wp_r        <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      tap_count_r <= TAP_COUNT_RESET;
    end else begin
      state_r     <= state_nxt;
      settle_r    <= settle_nxt;
      idx_r       <= idx_nxt;
      wp_r        <= wp_nxt;
      rd_v_r      <= rd_v_nxt;
      out_valid_r <= out_valid_nxt;
      tap_count_r <= tap_count_nxt;
    end
    hist_ptr_r     <= hist_ptr_nxt;
    level_r        <= level_nxt;
    out_filtered_r <= out_filtered_nxt;
  end

  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_wa] <= tap_wd;
    end
    tap_rd_r <= tap_mem[tap_ra];
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    hist_rd_r <= hist_mem[hist_ra];
  end

  a_round_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RND |-> !rd_v_r && !mac_sts.busy)
    else $error("rounding started with products still in flight");

  a_wp_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_action == ACT_SAMPLE && !cfg_wr |=> CW'(wp_r) < n_eff)
    else $error("write pointer left the ring");

  a_run_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |-> idx_r <= LAST_IDX)
    else $error("tap index beyond the store");

  a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && out_valid_r && !out_ready |=> state_r == S_OUT)
    else $error("result dropped while output register full");

endmodule

`default_nettype wire

/* hw/rtl/fir_q16_mac.sv */
// Shared multiply-accumulate unit: registered multiply, saturating 64-bit
// accumulate, and round-half-away / saturate to 32 bits. Uses fir_q16_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fir_q16_mac #(
  parameter int SAMPLE_BITS = fir_q16_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = fir_q16_pkg::FRAC_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  fir_q16_pkg::mac_ctl_t                     ctl_i,
  input  logic signed [fir_q16_pkg::TAP_BITS-1:0]   tap_i,
  input  logic signed [SAMPLE_BITS-1:0]             data_i,
  output fir_q16_pkg::mac_sts_t                     sts_o,
  output logic signed [fir_q16_pkg::OUT_BITS-1:0]   result_o
);
  import fir_q16_pkg::*;

  localparam int PROD_BITS = TAP_BITS + SAMPLE_BITS;
  localparam logic [ACC_BITS-1:0] HALF     = ACC_BITS'(1) << (FRAC_BITS - 1);
  localparam logic [ACC_BITS-1:0] HALF_P1  = HALF + ACC_BITS'(1);
  localparam logic [ACC_BITS-1:0] NEG_LIM  = ACC_BITS'(1) << (OUT_BITS - 1);
  localparam logic [ACC_BITS-1:0] POS_LIM  = NEG_LIM - ACC_BITS'(1);
  localparam logic [ACC_BITS-1:0] ACC_MIN  = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic [ACC_BITS-1:0] ACC_MAX  = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] OUT_MIN  = {1'b1, {(OUT_BITS-1){1'b0}}};
  localparam logic [OUT_BITS-1:0] OUT_MAX  = {1'b0, {(OUT_BITS-1){1'b1}}};

  logic signed [PROD_BITS-1:0] prod_r;
  logic                        pv_r;
  logic [ACC_BITS-1:0]         acc_r, acc_nxt;
  logic [ACC_BITS-1:0]         prod_ext;
  logic [ACC_BITS:0]           sum_ext;
  logic [ACC_BITS-1:0]         rnd_r, rnd_nxt;
  logic                        neg_r;
  logic [ACC_BITS-1:0]         mag;

  always_comb begin
    prod_ext = ACC_BITS'(prod_r);
    sum_ext  = {acc_r[ACC_BITS-1], acc_r} + {prod_ext[ACC_BITS-1], prod_ext};
    if (sum_ext[ACC_BITS] != sum_ext[ACC_BITS-1]) begin
      acc_nxt = sum_ext[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_nxt = sum_ext[ACC_BITS-1:0];
    end
    // |acc| + half in one adder
    rnd_nxt = acc_r[ACC_BITS-1] ? (~acc_r + HALF_P1) : (acc_r + HALF);
  end

  always_comb begin
    mag = rnd_r >> FRAC_BITS;
    if (neg_r) begin
      result_o = (mag > NEG_LIM) ? OUT_MIN
                                 : OUT_BITS'(~mag[OUT_BITS-1:0] + OUT_BITS'(1));
    end else begin
      result_o = (mag > POS_LIM) ? OUT_MAX : mag[OUT_BITS-1:0];
    end
  end

  assign sts_o.busy = pv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl_i.mul_v;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(tap_i) * PROD_BITS'(data_i);
    if (ctl_i.clear) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_nxt;
    end
    if (ctl_i.round) begin
      rnd_r <= rnd_nxt;
      neg_r <= acc_r[ACC_BITS-1];
    end
  end

endmodule

`default_nettype wire
